// ===== design/sphere_axis_slab_bounds_macros.svh =====
// assertion macros for the slab bounds block
`ifndef SPHERE_AXIS_SLAB_BOUNDS_MACROS_SVH
`define SPHERE_AXIS_SLAB_BOUNDS_MACROS_SVH

// next-cycle implication, off while in reset
`define SAB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sab assertion failed");

// next-cycle implication, also checked across reset
`define SAB_ASSERT_ALWAYS(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sab assertion failed");

`endif

// ===== design/sab_pkg.sv =====
// shared types and constants for the slab bounds block
`default_nettype none

package sab_pkg;

  localparam int IDX_W      = 4;
  localparam int AXC_W      = 16;
  localparam int CRD_W      = 24;
  localparam int RAD_W      = 23;
  localparam int BND_W      = 28;
  localparam int PROD_W     = CRD_W + AXC_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int FRAC_SH    = 14;
  localparam int CNTREG_W   = 5;
  localparam int IN_TDATA_W = 152;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPHERE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic signed [AXC_W-1:0] z;
    logic signed [AXC_W-1:0] y;
    logic signed [AXC_W-1:0] x;
  } axis_t;

  typedef struct packed {
    axis_t                   ax;
    logic signed [BND_W-1:0] lo;
    logic signed [BND_W-1:0] hi;
  } cell_t;

endpackage

`default_nettype wire

// ===== design/sab_cell.sv =====
// one ring cell: holds an axis entry and its running bounds
`default_nettype none

module sab_cell import sab_pkg::*; (
  input  logic  clk,
  input  logic  shift,
  input  cell_t nbr,
  input  logic  load_en,
  input  axis_t load_axis,
  output cell_t ent
);

  cell_t ent_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      ent_r <= nbr;
    end else if (load_en) begin
      ent_r.ax <= load_axis;
    end
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

// ===== design/sab_proj.sv =====
// projection stage: dot product of the head entry, then bounds update
`default_nettype none

module sab_proj import sab_pkg::*; (
  input  logic                    clk,
  input  logic                    step,
  input  logic                    upd,
  input  logic                    first,
  input  logic signed [CRD_W-1:0] cx,
  input  logic signed [CRD_W-1:0] cy,
  input  logic signed [CRD_W-1:0] cz,
  input  logic [RAD_W-1:0]        radius,
  input  cell_t                   ent_in,
  output cell_t                   ent_out
);

  cell_t                    ent_r;
  logic                     upd_r;
  logic signed [PROD_W-1:0] px_r;
  logic signed [PROD_W-1:0] py_r;
  logic signed [PROD_W-1:0] pz_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [BND_W-1:0]  d;
  logic signed [BND_W-1:0]  dm;
  logic signed [BND_W-1:0]  dp;
  logic signed [BND_W-1:0]  rad_ext;

  always_ff @(posedge clk) begin
    if (step) begin
      ent_r <= ent_in;
      upd_r <= upd;
      px_r  <= cx * ent_in.ax.x;
      py_r  <= cy * ent_in.ax.y;
      pz_r  <= cz * ent_in.ax.z;
    end
  end

  always_comb begin
    sum     = SUM_W'(px_r) + SUM_W'(py_r) + SUM_W'(pz_r);
    // floor by the axis fraction bits
    d       = sum[SUM_W-1:FRAC_SH];
    rad_ext = $signed({{(BND_W-RAD_W){1'b0}}, radius});
    dm      = d - rad_ext;
    dp      = d + rad_ext;
    ent_out = ent_r;
    if (upd_r) begin
      if (first || dm < ent_r.lo) begin
        ent_out.lo = dm;
      end
      if (first || dp > ent_r.hi) begin
        ent_out.hi = dp;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/sphere_axis_slab_bounds.sv =====
// a load item is taken without closing the input; a sphere holds the input closed after its accept
// while the ring takes MAX_AXES+1 steps through the single projection stage
// a last sphere adds a drain of MAX_AXES+1 ring steps before the input reopens; the results
// leave from the head during the drain, one item per axis in use, and each stalled result
// holds the drain
// reset clears control state and sets axis_count to 3; axis entries hold nothing until loaded
`default_nettype none

module sphere_axis_slab_bounds import sab_pkg::*; #(
  parameter int MAX_AXES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // axis_index, axis_x, axis_y, axis_z, center_x, center_y, center_z, radius, zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op
  input  logic [0:0]             in_tuser,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_axis, bound_min, bound_max, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_wr_en,
  input  logic [CNTREG_W-1:0]    cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_AXES + 2);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 first_r, first_nxt;
  logic [CNTREG_W-1:0]  axis_count_r;
  logic                 last_r;
  logic signed [CRD_W-1:0] cx_r, cy_r, cz_r;
  logic [RAD_W-1:0]     rad_r;

  logic                 out_valid_r;
  logic [IDX_W-1:0]     out_axis_r;
  logic signed [BND_W-1:0] out_min_r, out_max_r;
  logic                 out_last_r;

  logic                 in_acc, load_go, sphere_go;
  logic                 shift, upd, emit, ring_end;
  logic                 out_free;
  logic [CNT_W-1:0]     used;
  axis_t                load_axis;
  cell_t                ring [MAX_AXES];
  cell_t                proj_out;

  assign in_acc    = in_tvalid && in_tready;
  assign load_go   = in_acc && !in_tuser[0];
  assign sphere_go = in_acc && in_tuser[0];
  assign load_axis = '{z: in_tdata[51:36], y: in_tdata[35:20], x: in_tdata[19:4]};
  assign out_free  = !out_valid_r || out_tready;
  assign ring_end  = (cnt_r == CNT_W'(MAX_AXES));

  always_comb begin
    if (axis_count_r == '0) begin
      used = CNT_W'(1);
    end else if (int'(axis_count_r) > MAX_AXES) begin
      used = CNT_W'(MAX_AXES);
    end else begin
      used = CNT_W'(axis_count_r);
    end
  end

  // ring of cells; the projection stage closes the loop from head to tail
  for (genvar i = 0; i < MAX_AXES; i++) begin : g_cell
    cell_t nbr;
    logic  ld;
    if (i == MAX_AXES - 1) begin : g_tail
      assign nbr = proj_out;
    end else begin : g_mid
      assign nbr = ring[i+1];
    end
    assign ld = load_go && (int'(in_tdata[IDX_W-1:0]) == i);
    sab_cell u_cell (
      .clk       (clk),
      .shift     (shift),
      .nbr       (nbr),
      .load_en   (ld),
      .load_axis (load_axis),
      .ent       (ring[i])
    );
  end

  sab_proj u_proj (
    .clk     (clk),
    .step    (shift),
    .upd     (upd),
    .first   (first_r),
    .cx      (cx_r),
    .cy      (cy_r),
    .cz      (cz_r),
    .radius  (rad_r),
    .ent_in  (ring[0]),
    .ent_out (proj_out)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    in_tready = 1'b0;
    shift     = 1'b0;
    upd       = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (sphere_go) begin
          state_nxt = ST_SPHERE;
          cnt_nxt   = '0;
        end
      end
      ST_SPHERE: begin
        shift   = 1'b1;
        upd     = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (ring_end) begin
          cnt_nxt = '0;
          if (last_r) begin
            state_nxt = ST_DRAIN;
            first_nxt = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
            first_nxt = 1'b0;
          end
        end
      end
      ST_DRAIN: begin
        // entries in use leave from the head as the ring turns home
        shift = (cnt_r >= used) || out_free;
        emit  = shift && (cnt_r < used);
        if (shift) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (ring_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      first_r      <= 1'b1;
      axis_count_r <= CNTREG_W'(3);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      if (cfg_wr_en) begin
        axis_count_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sphere_go) begin
      cx_r   <= in_tdata[75:52];
      cy_r   <= in_tdata[99:76];
      cz_r   <= in_tdata[123:100];
      rad_r  <= in_tdata[146:124];
      last_r <= in_tlast;
    end
    if (emit) begin
      out_axis_r <= IDX_W'(cnt_r);
      out_min_r  <= ring[0].lo;
      out_max_r  <= ring[0].hi;
      out_last_r <= (cnt_r == used - CNT_W'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-IDX_W-2*BND_W){1'b0}}, out_max_r, out_min_r, out_axis_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== design/sab_checker.sv =====
// port-level checks for the slab bounds block, bound to the top level
`default_nettype none
`include "sphere_axis_slab_bounds_macros.svh"

module sab_checker import sab_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [0:0]             in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast
);

  // a stalled result item holds
  `SAB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  // a sphere keeps the input closed while the ring turns
  `SAB_ASSERT_NEXT(a_sphere_busy, in_tvalid && in_tready && in_tuser[0], !in_tready)
  // a load item finishes in its own cycle
  `SAB_ASSERT_NEXT(a_load_quick, in_tvalid && in_tready && !in_tuser[0], in_tready)
  // reset leaves the block open with nothing to send
  `SAB_ASSERT_ALWAYS(a_reset_clean, !rst_n, in_tready && !out_tvalid)

endmodule

bind sphere_axis_slab_bounds sab_checker u_sab_checker (.*);

`default_nettype wire
